// ===== hw/rtl/pin_ownership_table_top_assert.svh =====
// Assertion macros for the pin ownership table checker.
// Clocked on clk, disabled while rst is high; used by pot_checker.
`ifndef PIN_OWNERSHIP_TABLE_TOP_ASSERT_SVH
`define PIN_OWNERSHIP_TABLE_TOP_ASSERT_SVH

// Same-cycle implication.
`define POT_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define POT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/pot_pkg.sv =====
// Shared types, codes and sizes for the pin ownership table.
// No dependencies; imported by pot_eval, the top level and the checker.
package pot_pkg;

  localparam int MAX_PINS   = 64;
  localparam int OWNER_BITS = 8;

  localparam int OP_W       = 3;
  localparam int PIN_W      = 6;
  localparam int OWN_W      = 8;
  localparam int ST_W       = 2;
  localparam int STAT_W     = 3;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Only pins reachable through the pin field need table storage.
  localparam int TBL_DEPTH = (MAX_PINS < (1 << PIN_W)) ? MAX_PINS : (1 << PIN_W);
  localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

  localparam logic [OWN_W-1:0] OWNER_MASK =
    (OWNER_BITS >= OWN_W) ? {OWN_W{1'b1}} : OWN_W'((64'd1 << OWNER_BITS) - 64'd1);

  // ops
  localparam logic [OP_W-1:0] OP_RESERVE = 3'd0;
  localparam logic [OP_W-1:0] OP_CLAIM   = 3'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
  localparam logic [OP_W-1:0] OP_SET_ISR = 3'd3;
  localparam logic [OP_W-1:0] OP_REL_ALL = 3'd4;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd5;

  // entry states
  localparam logic [ST_W-1:0] ST_FREE = 2'd0;
  localparam logic [ST_W-1:0] ST_RESV = 2'd1;
  localparam logic [ST_W-1:0] ST_HELD = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_BUSY      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_DENIED    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOT_HELD  = 3'd4;
  localparam logic [STAT_W-1:0] STAT_NOT_OWNER = 3'd5;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_OWNER = 2'd1;

  typedef struct packed {
    logic [ST_W-1:0]  st;
    logic [OWN_W-1:0] own;
    logic             isr;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [PIN_W-1:0] pin;
    logic [OWN_W-1:0] who;
    logic             flag;
  } req_t;

  typedef struct packed {
    logic              wr;
    entry_t            wdata;
    logic [CNT_W-1:0]  nonfree_next;
    logic [STAT_W-1:0] status;
    entry_t            rep;
    logic              writable;
    logic              reservable;
    logic              held_by_asker;
  } eval_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PIN_W-1:0]  pin;
    entry_t            ent;
    logic              writable;
    logic              reservable;
    logic              held_by_asker;
    logic [CNT_W-1:0]  freed;
    logic [CNT_W-1:0]  total;
    logic              last;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RMW   = 4'b0010,
    S_COUNT = 4'b0100,
    S_FREE  = 4'b1000
  } state_t;

endpackage

// ===== hw/rtl/pot_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/pot_eval.sv =====
// Single-pin request evaluation: status, entry update and reported flags.
// Depends on pot_pkg.
module pot_eval (
  input  pot_pkg::req_t                 req,
  input  pot_pkg::entry_t               ent,
  input  logic                          in_range,
  input  logic [pot_pkg::OWN_W-1:0]     kown,
  input  logic [pot_pkg::CNT_W-1:0]     nonfree,
  output pot_pkg::eval_t                ev
);
  import pot_pkg::*;

  logic   bad;
  logic   held;
  logic   mine;
  entry_t rep;

  always_comb begin
    bad  = !in_range || (req.op > OP_QUERY);
    held = (ent.st == ST_HELD);
    mine = held && (ent.own == req.who);

    ev              = '0;
    ev.wdata        = ent;
    ev.nonfree_next = nonfree;
    ev.status       = STAT_OK;

    if (bad) begin
      ev.status = STAT_RANGE;
    end else begin
      unique case (req.op)
        OP_RESERVE: begin
          if (held) begin
            ev.status = STAT_BUSY;
          end else begin
            ev.wr    = 1'b1;
            ev.wdata = '{st: ST_RESV, own: kown, isr: 1'b0};
            if (ent.st == ST_FREE) begin
              ev.nonfree_next = CNT_W'(nonfree + 1'b1);
            end
          end
        end
        OP_CLAIM: begin
          if (ent.st == ST_RESV) begin
            ev.status = STAT_DENIED;
          end else if (held && !mine) begin
            ev.status = STAT_BUSY;
          end else begin
            ev.wr       = 1'b1;
            ev.wdata.st = ST_HELD;
            ev.wdata.own = req.who;
            if (ent.st == ST_FREE) begin
              ev.nonfree_next = CNT_W'(nonfree + 1'b1);
            end
          end
        end
        OP_RELEASE: begin
          if (!held) begin
            ev.status = (ent.st == ST_RESV) ? STAT_DENIED : STAT_NOT_HELD;
          end else if (!mine) begin
            ev.status = STAT_NOT_OWNER;
          end else begin
            ev.wr    = 1'b1;
            ev.wdata = '0;
            if (nonfree != '0) begin
              ev.nonfree_next = CNT_W'(nonfree - 1'b1);
            end
          end
        end
        OP_SET_ISR: begin
          if (!mine) begin
            ev.status = STAT_NOT_OWNER;
          end else begin
            ev.wr        = 1'b1;
            ev.wdata.isr = req.flag;
          end
        end
        default: ;  // query: read only
      endcase
    end

    // release reports the entry as it was; other ops the entry after; out-of-range a zero entry
    if (bad) begin
      rep = '0;
    end else if (req.op == OP_RELEASE || !ev.wr) begin
      rep = ent;
    end else begin
      rep = ev.wdata;
    end

    ev.rep           = rep;
    ev.writable      = !bad && ((rep.st == ST_FREE) ||
                                (rep.st == ST_HELD && rep.own == req.who));
    ev.reservable    = !bad && (rep.st != ST_HELD);
    ev.held_by_asker = !bad && (rep.st == ST_HELD) && (rep.own == req.who);
  end

endmodule

// ===== hw/rtl/pin_ownership_table_top.sv =====
// Pin ownership table: one entry per pin (state, owner, interrupt flag) kept in a
// single-port-read RAM with a registered read; depends on pot_pkg, pot_ram, pot_eval.
//
// A single-pin request (reserve, claim, release, set interrupt flag, query)
// issues the table read in the accept cycle; the entry is evaluated and
// written back in the RMW state, once the result register is free. Release
// all of an owner runs two passes over the pins in range: a counting pass
// over pin_count pins (saturated to the table depth), then a freeing pass
// that emits one item per freed pin, at most one per cycle when the output
// does not stall. If the owner holds nothing, one item with status ok and
// last set comes back. Every item carries claimed_total as it stands after
// the whole request, so the count is known before the first freed pin is
// reported. Reset and a pin_count write clear the table at once through
// per-entry valid bits; no clearing pass is needed. The result sits in an
// output register, so a new request is taken while the previous result
// still waits on rsp_stall. Configuration (cfg_ready is always high) must be
// written only while idle; the block does not enforce it.
module pin_ownership_table_top (
  input  logic                               clk,
  input  logic                               rst,
  // request channel
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [pot_pkg::OP_W-1:0]           op,
  input  logic [pot_pkg::PIN_W-1:0]          pin,
  input  logic [pot_pkg::OWN_W-1:0]          owner,
  input  logic                               isr_flag,
  // result channel
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic [pot_pkg::STAT_W-1:0]         status,
  output logic [pot_pkg::PIN_W-1:0]          pin_out,
  output logic [pot_pkg::ST_W-1:0]           pin_state,
  output logic [pot_pkg::OWN_W-1:0]          owner_out,
  output logic                               isr_out,
  output logic                               writable,
  output logic                               reservable,
  output logic                               held_by_asker,
  output logic [pot_pkg::CNT_W-1:0]          freed_count,
  output logic [pot_pkg::CNT_W-1:0]          claimed_total,
  output logic                               last,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pot_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pot_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pot_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TBL_DEPTH);

  // control
  state_t               state;
  logic [TBL_AW-1:0]    idx;
  logic [CNT_W-1:0]     cnt;        // matches seen in counting pass
  logic [CNT_W-1:0]     total;      // pins to free in this release all
  logic [CNT_W-1:0]     freed;      // pins freed so far
  logic [CNT_W-1:0]     nonfree;
  logic [CNT_W-1:0]     pin_count;
  logic [OWN_W-1:0]     kown;
  logic [TBL_DEPTH-1:0] vld;
  logic                 rd_vld;

  // payload
  req_t                 req;
  rsp_t                 rsp;

  // table port
  logic                 ram_we;
  logic [TBL_AW-1:0]    ram_waddr;
  entry_t               ram_wdata;
  logic [TBL_AW-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]   ram_q;

  entry_t               ent;
  eval_t                ev;
  logic [CNT_W-1:0]     lim;
  logic                 in_range;
  logic                 req_acc;
  logic                 slot_free;
  logic                 match;
  logic                 scan_end;
  logic [CNT_W-1:0]     cnt_total;
  logic [CNT_W-1:0]     freed_inc;
  logic                 free_emit;
  logic                 free_adv;
  logic                 rmw_done;
  logic                 empty_emit;
  logic                 rsp_load;
  logic [CNT_W-1:0]     pc_in;

  assign cfg_ready = 1'b1;
  assign req_stall = !(state == S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign slot_free = !rsp_valid || !rsp_stall;

  // pins scanned / in range: pin_count capped at the table depth
  assign lim      = (pin_count > DEPTH_C) ? DEPTH_C : pin_count;
  assign in_range = ({1'b0, req.pin} < lim);

  // never-written entries read as free
  assign ent       = rd_vld ? entry_t'(ram_q) : '0;
  assign match     = (ent.st == ST_HELD) && (ent.own == req.who);
  assign scan_end  = (CNT_W'(idx) == CNT_W'(lim - 1'b1));
  assign cnt_total = CNT_W'(cnt + CNT_W'(match));
  assign freed_inc = CNT_W'(freed + 1'b1);

  assign rmw_done   = (state == S_RMW) && slot_free;
  assign empty_emit = (state == S_FREE) && (total == '0) && slot_free;
  assign free_emit  = (state == S_FREE) && (total != '0) && match && slot_free;
  assign free_adv   = (state == S_FREE) && (total != '0) && (!match || slot_free);
  assign rsp_load   = rmw_done || empty_emit || free_emit;

  assign pc_in = (32'(cfg_data[CNT_W-1:0]) > MAX_PINS) ? CNT_W'(MAX_PINS)
                                                       : cfg_data[CNT_W-1:0];

  pot_eval u_eval (
    .req      (req),
    .ent      (ent),
    .in_range (in_range),
    .kown     (kown),
    .nonfree  (nonfree),
    .ev       (ev)
  );

  // read address: next entry is fetched while the current one is evaluated
  always_comb begin
    unique case (state)
      S_IDLE:  ram_raddr = (op == OP_REL_ALL) ? '0 : pin[TBL_AW-1:0];
      S_RMW:   ram_raddr = req.pin[TBL_AW-1:0];
      S_COUNT: ram_raddr = scan_end ? '0 : TBL_AW'(idx + 1'b1);
      S_FREE:  ram_raddr = free_adv ? TBL_AW'(idx + 1'b1) : idx;
      default: ram_raddr = idx;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '0;
    if (rmw_done && ev.wr) begin
      ram_we    = 1'b1;
      ram_waddr = req.pin[TBL_AW-1:0];
      ram_wdata = ev.wdata;
    end else if (free_emit) begin
      ram_we = 1'b1;
    end
  end

  pot_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      cnt       <= '0;
      total     <= '0;
      freed     <= '0;
      nonfree   <= '0;
      pin_count <= '0;
      kown      <= '0;
      vld       <= '0;
      rd_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_vld <= vld[ram_raddr];
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end

      // a new item is only loaded once the slot is free
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            idx   <= '0;
            cnt   <= '0;
            freed <= '0;
            total <= '0;
            if (op != OP_REL_ALL) begin
              state <= S_RMW;
            end else if (lim == '0) begin
              state <= S_FREE;
            end else begin
              state <= S_COUNT;
            end
          end
        end
        S_RMW: begin
          if (slot_free) begin
            nonfree <= ev.nonfree_next;
            state   <= S_IDLE;
          end
        end
        S_COUNT: begin
          if (scan_end) begin
            // claimed_total must be final on every item, so settle it now
            total   <= cnt_total;
            nonfree <= (nonfree > cnt_total) ? CNT_W'(nonfree - cnt_total) : '0;
            idx     <= '0;
            state   <= S_FREE;
          end else begin
            cnt <= cnt_total;
            idx <= TBL_AW'(idx + 1'b1);
          end
        end
        S_FREE: begin
          if (empty_emit) begin
            state <= S_IDLE;
          end else if (free_adv) begin
            idx <= TBL_AW'(idx + 1'b1);
            if (free_emit) begin
              freed <= freed_inc;
              if (freed_inc == total) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      // configuration must be written only while idle; the block does not enforce it
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PIN_COUNT: begin
            pin_count <= pc_in;
            vld       <= '0;
            nonfree   <= '0;
          end
          CFG_KERNEL_OWNER: kown <= cfg_data[OWN_W-1:0] & OWNER_MASK;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_acc) begin
      req.op   <= op;
      req.pin  <= pin;
      req.who  <= owner & OWNER_MASK;
      req.flag <= isr_flag;
    end

    if (rmw_done) begin
      rsp.status        <= ev.status;
      rsp.pin           <= req.pin;
      rsp.ent           <= ev.rep;
      rsp.writable      <= ev.writable;
      rsp.reservable    <= ev.reservable;
      rsp.held_by_asker <= ev.held_by_asker;
      rsp.freed         <= '0;
      rsp.total         <= ev.nonfree_next;
      rsp.last          <= 1'b1;
    end else if (empty_emit) begin
      rsp <= '{status: STAT_OK, pin: '0, ent: '0, writable: 1'b0, reservable: 1'b0,
               held_by_asker: 1'b0, freed: '0, total: nonfree, last: 1'b1};
    end else if (free_emit) begin
      // entry as it was before freeing
      rsp.status        <= STAT_OK;
      rsp.pin           <= PIN_W'(idx);
      rsp.ent           <= '{st: ST_HELD, own: req.who, isr: ent.isr};
      rsp.writable      <= 1'b1;
      rsp.reservable    <= 1'b0;
      rsp.held_by_asker <= 1'b1;
      rsp.freed         <= freed_inc;
      rsp.total         <= nonfree;
      rsp.last          <= (freed_inc == total);
    end
  end

  assign status        = rsp.status;
  assign pin_out       = rsp.pin;
  assign pin_state     = rsp.ent.st;
  assign owner_out     = rsp.ent.own;
  assign isr_out       = rsp.ent.isr;
  assign writable      = rsp.writable;
  assign reservable    = rsp.reservable;
  assign held_by_asker = rsp.held_by_asker;
  assign freed_count   = rsp.freed;
  assign claimed_total = rsp.total;
  assign last          = rsp.last;

endmodule

// ===== hw/rtl/pot_checker.sv =====
// Port-level checks for the pin ownership table, bound to the top level.
// Depends on pot_pkg and pin_ownership_table_top_assert.svh.
`include "pin_ownership_table_top_assert.svh"

module pot_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               rsp_valid,
  input logic                               rsp_stall,
  input logic [pot_pkg::STAT_W-1:0]         status,
  input logic [pot_pkg::PIN_W-1:0]          pin_out,
  input logic [pot_pkg::ST_W-1:0]           pin_state,
  input logic [pot_pkg::OWN_W-1:0]          owner_out,
  input logic                               isr_out,
  input logic                               writable,
  input logic                               reservable,
  input logic                               held_by_asker,
  input logic [pot_pkg::CNT_W-1:0]          freed_count,
  input logic [pot_pkg::CNT_W-1:0]          claimed_total,
  input logic                               last
);
  import pot_pkg::*;

  // stalled item holds
  `POT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(pin_out) && $stable(claimed_total) && $stable(last), "result changed while stalled")

  // out-of-range items carry an empty entry and are single
  `POT_ASSERT_HOLDS(a_range_clean, rsp_valid && status == STAT_RANGE, pin_state == ST_FREE && owner_out == '0 && !isr_out && !writable && !reservable && !held_by_asker && last, "out-of-range item not clean")

  // held by asker implies a held, writable, non-reservable entry
  `POT_ASSERT_HOLDS(a_held_flags, rsp_valid && held_by_asker, pin_state == ST_HELD && writable && !reservable, "held_by_asker flags inconsistent")

  // freed pins come only from a successful release all
  `POT_ASSERT_HOLDS(a_freed_ok, rsp_valid && freed_count != '0, status == STAT_OK && held_by_asker && freed_count <= claimed_total + CNT_W'(TBL_DEPTH), "freed item malformed")

  // every item other than a freed pin is the only one of its request
  `POT_ASSERT_HOLDS(a_single_last, rsp_valid && freed_count == '0, last, "single item without last")

endmodule

bind pin_ownership_table_top pot_checker u_pot_checker (.*);

// ===== tb/pin_ownership_table_top_test.sv =====
// Self-checking testbench for pin_ownership_table_top: directed table, then random traffic.
// Uses pot_pkg for widths, op/state/status codes and the result struct; needs only the RTL.
`timescale 1ns / 1ps

module pin_ownership_table_top_test;
  import pot_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 95;
  localparam int MAX_SHOWN    = 10;

  // op codes the block must refuse as out of range
  localparam logic [OP_W-1:0] OP_BAD_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_BAD_HI = 3'd7;
  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd2;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // one line of the directed script: a request or a register write
  typedef struct packed {
    row_kind_t              kind;
    logic [OP_W-1:0]        op;
    logic [PIN_W-1:0]       pin;
    logic [OWN_W-1:0]       who;
    logic                   flag;
    logic                   typed;   // status below is the expected one
    logic [STAT_W-1:0]      want;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic [OP_W-1:0]       op = '0;
  logic [PIN_W-1:0]      pin = '0;
  logic [OWN_W-1:0]      owner = '0;
  logic                  isr_flag = 1'b0;

  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic [STAT_W-1:0]     status;
  logic [PIN_W-1:0]      pin_out;
  logic [ST_W-1:0]       pin_state;
  logic [OWN_W-1:0]      owner_out;
  logic                  isr_out;
  logic                  writable;
  logic                  reservable;
  logic                  held_by_asker;
  logic [CNT_W-1:0]      freed_count;
  logic [CNT_W-1:0]      claimed_total;
  logic                  last;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pin_ownership_table_top uut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .op            (op),
    .pin           (pin),
    .owner         (owner),
    .isr_flag      (isr_flag),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .pin_out       (pin_out),
    .pin_state     (pin_state),
    .owner_out     (owner_out),
    .isr_out       (isr_out),
    .writable      (writable),
    .reservable    (reservable),
    .held_by_asker (held_by_asker),
    .freed_count   (freed_count),
    .claimed_total (claimed_total),
    .last          (last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the pin table and the two registers.
  // ---------------------------------------------------------------------------
  logic [ST_W-1:0]  pin_st  [MAX_PINS];
  logic [OWN_W-1:0] pin_own [MAX_PINS];
  logic             pin_isr [MAX_PINS];
  int               nonfree_pins;
  int               cur_pin_count;
  logic [OWN_W-1:0] cur_kernel_id;

  rsp_t pending_rsp[$];   // results still owed by the block, oldest first

  int mismatches  = 0;
  int rsp_seen    = 0;
  int cycles      = 0;
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int holds_asked = 0;
  int holds_done  = 0;
  int hold_left   = 0;

  task automatic clear_pin_table();
    for (int i = 0; i < MAX_PINS; i++) begin
      pin_st[i]  = ST_FREE;
      pin_own[i] = '0;
      pin_isr[i] = 1'b0;
    end
    nonfree_pins = 0;
  endtask

  task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
    int v;
    if (idx == CFG_PIN_COUNT) begin
      v = int'(data & 8'h7f);
      cur_pin_count = (v > MAX_PINS) ? MAX_PINS : v;
      clear_pin_table();   // a pin_count write wipes the table
    end else if (idx == CFG_KERNEL_OWNER) begin
      cur_kernel_id = data & OWNER_MASK;
    end
  endtask

  // Works out every result one request causes and updates the shadow table.
  task automatic predict_pin_request(input logic [OP_W-1:0] o, input logic [PIN_W-1:0] p,
                                     input logic [OWN_W-1:0] who_in, input logic f);
    rsp_t             r;
    logic [OWN_W-1:0] who;
    logic [ST_W-1:0]  st;
    logic [OWN_W-1:0] own;
    logic             isr;
    logic             report_before;
    logic [PIN_W-1:0] gone_pin [MAX_PINS];
    logic             gone_isr [MAX_PINS];
    int               n;
    who = who_in & OWNER_MASK;
    r = '0;
    r.last = 1'b1;

    if (o == OP_REL_ALL) begin
      n = 0;
      for (int i = 0; i < cur_pin_count && n < MAX_PINS; i++) begin
        if (pin_st[i] == ST_HELD && pin_own[i] == who) begin
          gone_pin[n] = PIN_W'(i);
          gone_isr[n] = pin_isr[i];
          pin_st[i]  = ST_FREE;
          pin_own[i] = '0;
          pin_isr[i] = 1'b0;
          if (nonfree_pins > 0) nonfree_pins--;
          n++;
        end
      end
      if (n == 0) begin
        // nothing held by this owner: one empty ok result
        r.total = CNT_W'(nonfree_pins);
        pending_rsp.push_back(r);
      end else begin
        for (int k = 0; k < n; k++) begin
          r.status        = STAT_OK;
          r.pin           = gone_pin[k];
          r.ent.st        = ST_HELD;
          r.ent.own       = who;
          r.ent.isr       = gone_isr[k];
          r.writable      = 1'b1;
          r.reservable    = 1'b0;
          r.held_by_asker = 1'b1;
          r.freed         = CNT_W'(k + 1);
          r.total         = CNT_W'(nonfree_pins);   // count after the whole scan
          r.last          = (k + 1 == n);
          pending_rsp.push_back(r);
        end
      end
      return;
    end

    // unknown op or pin outside pin_count: entry fields stay zero
    if (o > OP_QUERY || int'(p) >= cur_pin_count) begin
      r.status = STAT_RANGE;
      r.pin    = p;
      r.total  = CNT_W'(nonfree_pins);
      pending_rsp.push_back(r);
      return;
    end

    st  = pin_st[p];
    own = pin_own[p];
    isr = pin_isr[p];
    report_before = 1'b0;
    r.status = STAT_OK;

    case (o)
      OP_RESERVE: begin
        if (st == ST_HELD) begin
          r.status = STAT_BUSY;
        end else begin
          if (st == ST_FREE) nonfree_pins++;
          pin_st[p]  = ST_RESV;
          pin_own[p] = cur_kernel_id;
          pin_isr[p] = 1'b0;
        end
      end
      OP_CLAIM: begin
        if (st == ST_RESV) begin
          r.status = STAT_DENIED;
        end else if (st == ST_HELD && own != who) begin
          r.status = STAT_BUSY;
        end else begin
          if (st == ST_FREE) nonfree_pins++;
          pin_st[p]  = ST_HELD;   // isr flag kept on a repeat claim
          pin_own[p] = who;
        end
      end
      OP_RELEASE: begin
        report_before = 1'b1;
        if (st != ST_HELD) begin
          r.status = (st == ST_RESV) ? STAT_DENIED : STAT_NOT_HELD;
        end else if (own != who) begin
          r.status = STAT_NOT_OWNER;
        end else begin
          pin_st[p]  = ST_FREE;
          pin_own[p] = '0;
          pin_isr[p] = 1'b0;
          if (nonfree_pins > 0) nonfree_pins--;
        end
      end
      OP_SET_ISR: begin
        if (st != ST_HELD || own != who) r.status = STAT_NOT_OWNER;
        else pin_isr[p] = f;
      end
      default: ;
    endcase

    if (!report_before) begin
      st  = pin_st[p];
      own = pin_own[p];
      isr = pin_isr[p];
    end
    r.pin           = p;
    r.ent.st        = st;
    r.ent.own       = own;
    r.ent.isr       = isr;
    r.writable      = (st == ST_FREE) || (st == ST_HELD && own == who);
    r.reservable    = (st != ST_HELD);
    r.held_by_asker = (st == ST_HELD && own == who);
    r.total         = CNT_W'(nonfree_pins);
    pending_rsp.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Request side. Valid is lowered only during a random gap or when draining,
  // so back-to-back items keep valid high with a new payload.
  // ---------------------------------------------------------------------------
  task automatic offer_request(input logic [OP_W-1:0] o, input logic [PIN_W-1:0] p,
                               input logic [OWN_W-1:0] w, input logic f);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    op        <= o;
    pin       <= p;
    owner     <= w;
    isr_flag  <= f;
    do @(posedge clk); while (req_stall);
    predict_pin_request(o, p, w, f);
  endtask

  // Block idle: no request offered and every owed result back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg_write(idx, data);
    cfg_valid <= 1'b0;
  endtask

  function automatic step_t req_row(logic [OP_W-1:0] o, logic [PIN_W-1:0] p,
                                    logic [OWN_W-1:0] w, logic f, logic typed,
                                    logic [STAT_W-1:0] want);
    step_t s;
    s = '0;
    s.kind  = ROW_REQ;
    s.op    = o;
    s.pin   = p;
    s.who   = w;
    s.flag  = f;
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  function automatic step_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    step_t s;
    s = '0;
    s.kind = ROW_CFG;
    s.idx  = idx;
    s.data = data;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall, forced stall during a hold-off, and the check.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (holds_asked != holds_done) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : rsp_check
    rsp_t got;
    rsp_t want;
    logic bad;
    if (!rst && rsp_valid && !rsp_stall) begin
      got.status        = status;
      got.pin           = pin_out;
      got.ent.st        = pin_state;
      got.ent.own       = owner_out;
      got.ent.isr       = isr_out;
      got.writable      = writable;
      got.reservable    = reservable;
      got.held_by_asker = held_by_asker;
      got.freed         = freed_count;
      got.total         = claimed_total;
      got.last          = last;
      if (pending_rsp.size() == 0) begin
        if (mismatches < MAX_SHOWN)
          $display("result %0d arrived with nothing owed: %p", rsp_seen, got);
        mismatches++;
      end else begin
        want = pending_rsp.pop_front();
        bad = (got.status !== want.status) || (got.pin !== want.pin) ||
              (got.ent.st !== want.ent.st) || (got.ent.own !== want.ent.own) ||
              (got.ent.isr !== want.ent.isr) || (got.writable !== want.writable) ||
              (got.reservable !== want.reservable) ||
              (got.held_by_asker !== want.held_by_asker) ||
              (got.freed !== want.freed) || (got.total !== want.total) ||
              (got.last !== want.last);
        if (bad) begin
          if (mismatches < MAX_SHOWN) begin
            $display("result %0d differs", rsp_seen);
            $display("  want %p", want);
            $display("  got  %p", got);
          end
          mismatches++;
        end
      end
      rsp_seen++;
    end
    rsp_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
  end

  // Watchdog: a hang or a result that never comes ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    step_t            script[$];
    step_t            s;
    rsp_t             r;
    logic [OWN_W-1:0] pool [4];
    int               phase_pins [4];
    int               phase_idle [4];
    int               phase_stall [4];
    int               pick;
    logic [OP_W-1:0]  o;
    logic [PIN_W-1:0] p;

    clear_pin_table();
    cur_pin_count = 0;
    cur_kernel_id = '0;

    // Directed part. Reset leaves pin_count at zero, so every pin starts out of
    // range; then the full 64 pins (written as 200 to hit saturation) with the
    // top kernel id, and finally a single pin.
    script = '{
      req_row(OP_QUERY,   0,   0,   0, 1, STAT_RANGE),
      req_row(OP_REL_ALL, 0,   0,   0, 1, STAT_OK),      // nothing to free
      req_row(OP_CLAIM,   63,  255, 1, 1, STAT_RANGE),
      reg_row(CFG_PIN_COUNT,    8'd200),
      reg_row(CFG_KERNEL_OWNER, 8'd255),
      reg_row(CFG_UNUSED,       8'h5a),                  // must change nothing
      req_row(OP_RESERVE, 0,   0,   0, 1, STAT_OK),
      req_row(OP_RESERVE, 0,   7,   1, 1, STAT_OK),      // re-reserve
      req_row(OP_CLAIM,   0,   5,   0, 1, STAT_DENIED),
      req_row(OP_RELEASE, 0,   5,   0, 1, STAT_DENIED),
      req_row(OP_RELEASE, 1,   5,   0, 1, STAT_NOT_HELD),
      req_row(OP_CLAIM,   63,  255, 0, 1, STAT_OK),
      req_row(OP_CLAIM,   63,  255, 1, 1, STAT_OK),      // same owner again
      req_row(OP_CLAIM,   63,  0,   0, 1, STAT_BUSY),
      req_row(OP_SET_ISR, 63,  255, 1, 1, STAT_OK),
      req_row(OP_SET_ISR, 63,  0,   1, 1, STAT_NOT_OWNER),
      req_row(OP_SET_ISR, 1,   0,   0, 1, STAT_NOT_OWNER),
      req_row(OP_RESERVE, 63,  0,   0, 1, STAT_BUSY),
      req_row(OP_RELEASE, 63,  0,   0, 1, STAT_NOT_OWNER),
      req_row(OP_QUERY,   63,  255, 0, 0, STAT_OK),
      req_row(OP_QUERY,   0,   0,   0, 0, STAT_OK),
      req_row(OP_CLAIM,   62,  255, 0, 1, STAT_OK),
      req_row(OP_BAD_LO,  10,  3,   1, 1, STAT_RANGE),
      req_row(OP_BAD_HI,  63,  255, 1, 1, STAT_RANGE),
      req_row(OP_REL_ALL, 0,   255, 0, 0, STAT_OK),      // frees 62 and 63
      req_row(OP_RELEASE, 62,  255, 0, 1, STAT_NOT_HELD),
      reg_row(CFG_PIN_COUNT,    8'd1),
      reg_row(CFG_KERNEL_OWNER, 8'd0),
      req_row(OP_QUERY,   1,   0,   0, 1, STAT_RANGE),
      req_row(OP_CLAIM,   0,   0,   1, 1, STAT_OK),
      req_row(OP_REL_ALL, 0,   0,   0, 0, STAT_OK)
    };

    phase_pins  = '{64, 16, 0, 5};
    phase_idle  = '{0, 83, 0, 11};
    phase_stall = '{0, 0, 83, 11};
    phase_pins[2] = $urandom_range(63, 1);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      s = script[i];
      if (s.kind == ROW_CFG) begin
        write_reg(s.idx, s.data);
      end else begin
        offer_request(s.op, s.pin, s.who, s.flag);
        if (s.typed) begin
          // status read straight off the row rather than the shadow table
          r = pending_rsp.pop_back();
          r.status = s.want;
          pending_rsp.push_back(r);
        end
      end
    end

    // Random part: four phases, each with its own pin_count and idling mix.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_PIN_COUNT, CFG_DATA_W'(phase_pins[ph]));
      write_reg(CFG_KERNEL_OWNER, CFG_DATA_W'($urandom_range(255)));
      send_idle_pct = phase_idle[ph];
      stall_pct     = phase_stall[ph];
      // a few owners so claims collide; one of them is the kernel id
      for (int k = 0; k < 3; k++) pool[k] = OWN_W'($urandom_range(255));
      pool[3] = cur_kernel_id;

      if (ph == 0) begin
        // one owner takes every pin, then a release all frees all 64
        for (int k = 0; k < MAX_PINS; k++)
          offer_request(OP_CLAIM, PIN_W'(k), pool[0], 1'($urandom_range(1)));
        offer_request(OP_REL_ALL, PIN_W'($urandom_range(63)), pool[0], 1'b0);
        // long receiver hold-off while requests keep coming
        holds_asked = holds_asked + 1;
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        if ($urandom_range(99) < 15) begin
          // noise: any op code, pin and owner
          offer_request(OP_W'($urandom_range(7)), PIN_W'($urandom_range(63)),
                        OWN_W'($urandom_range(255)), 1'($urandom_range(1)));
        end else begin
          pick = $urandom_range(99);
          if (pick < 30)      o = OP_CLAIM;
          else if (pick < 50) o = OP_RELEASE;
          else if (pick < 60) o = OP_RESERVE;
          else if (pick < 75) o = OP_SET_ISR;
          else if (pick < 90) o = OP_QUERY;
          else                o = OP_REL_ALL;
          // mostly pins in range, now and then anywhere
          if (cur_pin_count > 0 && $urandom_range(9) != 0)
            p = PIN_W'($urandom_range(cur_pin_count - 1));
          else
            p = PIN_W'($urandom_range(63));
          offer_request(o, p, pool[$urandom_range(3)], 1'($urandom_range(1)));
        end
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);   // catch any result beyond what was owed
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
